### rtl/zenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zenc_pkg: shared types and constants of the Zeckendorf encoder
// Fibonacci table, controller state encoding, command and status bundles.
// ----------------------------------------------------------------------------
package zenc_pkg;

	localparam int VALUE_WIDTH_DEF = 40;
	localparam int NUM_FIBS_DEF    = 58;
	localparam int COUNT_WIDTH     = 5;

	// Table sized for the largest supported NUM_FIBS; F(65) fits in 64 bits.
	localparam int FIB_DEPTH = 64;
	localparam int FIB_IDX_W = 6;
	localparam int FIB_W     = 64;

	typedef logic [FIB_W-1:0] fib_tab_t [FIB_DEPTH];

	// Entry i holds F(i+2): 1, 2, 3, 5, 8, ...
	function automatic fib_tab_t fib_table();
		fib_tab_t         t;
		logic [FIB_W-1:0] a;
		logic [FIB_W-1:0] b;
		logic [FIB_W-1:0] c;
		a = FIB_W'(1);
		b = FIB_W'(2);
		for (int i = 0; i < FIB_DEPTH; i++) begin
			c    = a + b;
			t[i] = a;
			a    = b;
			b    = c;
		end
		return t;
	endfunction

	localparam fib_tab_t FIB_TAB = fib_table();

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic start;     // load a new word, reset the walk
		logic step;      // process one table entry
		logic load_out;  // move the finished result to the output register
	} cmd_t;

	typedef struct packed {
		logic last;      // walk is at the smallest entry
	} status_t;

endpackage
`default_nettype wire

### rtl/zenc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zenc_if: valid/ready channels of the Zeckendorf encoder
// Input channel carries the value, output channel carries mask and count.
// ----------------------------------------------------------------------------
interface zenc_in_if #(
	parameter int VALUE_WIDTH = 40
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface zenc_out_if #(
	parameter int NUM_FIBS    = 58,
	parameter int COUNT_WIDTH = 5
);
	logic                   valid;
	logic                   ready;
	logic [NUM_FIBS-1:0]    term_mask;
	logic [COUNT_WIDTH-1:0] term_count;

	modport source (output valid, output term_mask, output term_count, input ready);
	modport sink   (input valid, input term_mask, input term_count, output ready);
endinterface
`default_nettype wire

### rtl/zenc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zenc_datapath: greedy Fibonacci walk, one table entry per cycle
// Holds remainder, mask, count, skip flag, entry index and output register.
// ----------------------------------------------------------------------------
module zenc_datapath #(
	parameter int VALUE_WIDTH = 40,
	parameter int NUM_FIBS    = 58
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire zenc_pkg::cmd_t                  cmd,
	output      zenc_pkg::status_t               status,
	input  wire logic [VALUE_WIDTH-1:0]          value,
	output      logic [NUM_FIBS-1:0]             term_mask,
	output      logic [zenc_pkg::COUNT_WIDTH-1:0] term_count
);
	import zenc_pkg::*;

	localparam int IDX_W = (NUM_FIBS > 1) ? $clog2(NUM_FIBS) : 1;

	logic [IDX_W-1:0]       idx_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [NUM_FIBS-1:0]    mask_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   skip_q;
	logic [NUM_FIBS-1:0]    out_mask_q;
	logic [COUNT_WIDTH-1:0] out_count_q;

	logic [FIB_W-1:0] fib_cur;
	logic             fits;

	assign fib_cur     = FIB_TAB[FIB_IDX_W'(idx_q)];
	assign fits        = fib_cur <= FIB_W'(rem_q);
	assign status.last = (idx_q == IDX_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			mask_q  <= '0;
			count_q <= '0;
			skip_q  <= 1'b0;
		end else if (cmd.start) begin
			idx_q   <= IDX_W'(NUM_FIBS - 1);
			mask_q  <= '0;
			count_q <= '0;
			skip_q  <= 1'b0;
		end else if (cmd.step) begin
			if (idx_q != IDX_W'(0)) begin
				idx_q <= idx_q - IDX_W'(1);
			end
			if (skip_q) begin
				skip_q <= 1'b0;
			end else if (fits) begin
				mask_q[idx_q] <= 1'b1;
				count_q       <= count_q + COUNT_WIDTH'(1);
				skip_q        <= 1'b1;
			end
		end
	end

	// Remainder is payload only.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= value;
		end else if (cmd.step && !skip_q && fits) begin
			rem_q <= rem_q - fib_cur[VALUE_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_mask_q  <= '0;
			out_count_q <= '0;
		end else if (cmd.load_out) begin
			out_mask_q  <= mask_q;
			out_count_q <= count_q;
		end
	end

	assign term_mask  = out_mask_q;
	assign term_count = out_count_q;

	// Count always tracks the number of terms taken.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == COUNT_WIDTH'($countones(mask_q)))
		else $error("term count out of step with mask");

	// A skipped entry never takes a term.
	a_skip_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && !cmd.start && skip_q |=> mask_q == $past(mask_q))
		else $error("term taken on a skipped entry");

endmodule
`default_nettype wire

### rtl/zenc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zenc_ctrl: sequencer of the Zeckendorf encoder
// Accepts a word, runs the walk, hands the result to the output register.
// ----------------------------------------------------------------------------
module zenc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output      logic              in_ready,
	output      logic              out_valid,
	input  wire logic              out_ready,
	input  wire zenc_pkg::status_t status,
	output      zenc_pkg::cmd_t    cmd
);
	import zenc_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		in_ready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
				if (in_valid) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.step = 1'b1;
				if (status.last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for room in the output register
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// Never overwrite a result that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// An accepted word always starts the walk.
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_RUN)
		else $error("walk did not start");

	// The last entry leads straight to result hand-off.
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && status.last |=> state_q == ST_DONE)
		else $error("walk did not finish");

endmodule
`default_nettype wire

### rtl/zeckendorf_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// zeckendorf_encoder: greedy Zeckendorf representation of an unsigned word
// Mask of non-consecutive Fibonacci terms F(i+2) and their count.
// ----------------------------------------------------------------------------
// Usage:
//   operand : valid/ready sink, one VALUE_WIDTH-bit unsigned word per item.
//   result  : valid/ready source, term_mask (bit i = F(i+2)) and term_count.
// Timing:
//   A word is taken in the idle state, then the walk visits one Fibonacci
//   table entry per cycle, largest first, with one compare and subtract
//   each, then the hand-off state moves the result to the output register
//   and the sequencer returns to idle to take the next word. It takes no
//   new word before the last one has moved to the output register.
// Stall:
//   The output register holds a finished word while the next one is walked.
//   If the receiver still holds off when the next walk ends, the sequencer
//   waits with its result and takes no new word until room opens.
// Reset:
//   arst_n clears the sequencer and the output valid at once; no clearing
//   pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
module zeckendorf_encoder #(
	parameter int VALUE_WIDTH = zenc_pkg::VALUE_WIDTH_DEF,
	parameter int NUM_FIBS    = zenc_pkg::NUM_FIBS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	zenc_in_if.sink   operand,
	zenc_out_if.source result
);
	import zenc_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Sequencer: idle / walk / hand-off.
	zenc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (operand.valid),
		.in_ready  (operand.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Remainder, mask, count and output register.
	zenc_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.NUM_FIBS    (NUM_FIBS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.value      (operand.value),
		.term_mask  (result.term_mask),
		.term_count (result.term_count)
	);

endmodule
`default_nettype wire

### tb/tb_zeckendorf_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zeckendorf_encoder: self-checking bench for the Zeckendorf encoder
// Drives operand words over the valid/ready input channel and recomputes the
// greedy Fibonacci decomposition of every accepted word, then compares mask
// and count of each result word in order. Directed corner words come first,
// then random words, under three handshake idling mixes.
// ----------------------------------------------------------------------------
module tb_zeckendorf_encoder;

	localparam int VALUE_WIDTH = zenc_pkg::VALUE_WIDTH_DEF;
	localparam int NUM_FIBS    = zenc_pkg::NUM_FIBS_DEF;
	localparam int COUNT_WIDTH = zenc_pkg::COUNT_WIDTH;
	localparam int RANDOM_WORDS = 1850;

	typedef logic [VALUE_WIDTH-1:0] word_t;

	// One result word: term mask plus number of terms.
	typedef struct packed {
		logic [NUM_FIBS-1:0]    term_mask;
		logic [COUNT_WIDTH-1:0] term_count;
	} zeck_code_t;

	logic clk;
	logic arst_n;

	zenc_in_if  #(.VALUE_WIDTH(VALUE_WIDTH)) operand_bus ();
	zenc_out_if #(.NUM_FIBS(NUM_FIBS), .COUNT_WIDTH(COUNT_WIDTH)) result_bus ();

	zeckendorf_encoder #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.NUM_FIBS   (NUM_FIBS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.operand(operand_bus.sink),
		.result (result_bus.source)
	);

	// Fibonacci terms F(2), F(3), ... held by the bench itself.
	logic [63:0] fib_terms [NUM_FIBS];

	word_t      operand_words [$];   // words waiting to be driven
	zeck_code_t zeck_codes_due [$];  // codes the encoder still owes, oldest first

	int  words_queued;
	int  words_accepted;
	int  codes_checked;
	int  failures;
	int  top_term_hits;              // results that used the largest table entry
	int  max_count_seen;
	int  sender_idle_pct;
	int  receiver_idle_pct;
	bit  operand_taken;              // input handshake completed at last rising edge

	// Clock: 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Greedy walk, largest term first; a taken term forbids the next smaller one.
	function automatic zeck_code_t zeck_encode(input word_t value);
		zeck_code_t  code;
		logic [63:0] left;
		bit          skip_next;
		code      = '0;
		left      = 64'(value);
		skip_next = 1'b0;
		for (int i = NUM_FIBS - 1; i >= 0; i--) begin
			if (skip_next) begin
				skip_next = 1'b0;
			end else if (fib_terms[i] <= left) begin
				left                = left - fib_terms[i];
				code.term_mask[i]   = 1'b1;
				code.term_count     = code.term_count + 1'b1;
				skip_next           = 1'b1;
			end
		end
		return code;
	endfunction

	function automatic bit idle_roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	// Random operand: full-range and right-shifted noise, small numbers, neighbors of
	// Fibonacci terms, and sums of non-adjacent terms (deep walks with many terms).
	function automatic word_t random_word();
		logic [63:0] sum;
		int          idx;
		word_t       w;
		case ($urandom_range(4))
			0: begin
				w = word_t'({$urandom, $urandom});
			end
			1: begin
				w = word_t'($urandom_range(200));
			end
			2: begin
				idx = $urandom_range(NUM_FIBS - 1);
				w   = word_t'(fib_terms[idx] + 64'($signed($urandom_range(4)) - 2));
			end
			3: begin
				sum = '0;
				idx = $urandom_range(NUM_FIBS - 2);
				while (idx >= 0) begin
					if ($urandom_range(1)) begin
						sum = sum + fib_terms[idx];
						idx = idx - 2;
					end else begin
						idx = idx - 1;
					end
				end
				w = word_t'(sum);
			end
			default: begin
				w = word_t'({$urandom, $urandom}) >> $urandom_range(VALUE_WIDTH - 1);
			end
		endcase
		return w;
	endfunction

	// Driver: inputs move on the falling edge only.
	always @(negedge clk) begin
		if (!arst_n) begin
			operand_bus.valid <= 1'b0;
			result_bus.ready  <= 1'b0;
		end else begin
			// A word stays on the bus until taken; then load the next or idle.
			if (!operand_bus.valid || operand_taken) begin
				if (operand_words.size() != 0 && !idle_roll(sender_idle_pct)) begin
					operand_bus.value <= operand_words.pop_front();
					operand_bus.valid <= 1'b1;
				end else begin
					operand_bus.valid <= 1'b0;
				end
			end
			result_bus.ready <= !idle_roll(receiver_idle_pct);
		end
	end

	// Monitor: both handshakes are sampled at the rising edge.
	always @(posedge clk) begin
		zeck_code_t want;
		operand_taken = arst_n && operand_bus.valid && operand_bus.ready;
		if (operand_taken) begin
			zeck_codes_due = {zeck_codes_due, zeck_encode(operand_bus.value)};
			words_accepted++;
		end
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (zeck_codes_due.size() == 0) begin
				failures++;
				$display("%0t: result word with none pending: mask %h count %0d",
					$time, result_bus.term_mask, result_bus.term_count);
			end else begin
				want = zeck_codes_due.pop_front();
				codes_checked++;
				if (result_bus.term_mask !== want.term_mask) begin
					failures++;
					$display("%0t: term_mask mismatch: expected %h, actual %h",
						$time, want.term_mask, result_bus.term_mask);
				end
				if (result_bus.term_count !== want.term_count) begin
					failures++;
					$display("%0t: term_count mismatch: expected %0d, actual %0d",
						$time, want.term_count, result_bus.term_count);
				end
				if (want.term_mask[NUM_FIBS-1])
					top_term_hits++;
				if (int'(want.term_count) > max_count_seen)
					max_count_seen = int'(want.term_count);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		word_t       corner_words [$];

		arst_n             = 1'b0;
		operand_bus.valid  = 1'b0;
		operand_bus.value  = '0;
		result_bus.ready   = 1'b0;
		operand_taken      = 1'b0;
		words_queued       = 0;
		words_accepted     = 0;
		codes_checked      = 0;
		failures           = 0;
		top_term_hits      = 0;
		max_count_seen     = 0;
		sender_idle_pct    = 21;
		receiver_idle_pct  = 88;

		a = 64'd1;
		b = 64'd2;
		for (int i = 0; i < NUM_FIBS; i++) begin
			c            = a + b;
			fib_terms[i] = a;
			a            = b;
			b            = c;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Corners: zero, tiny values, the largest term and its neighbors, the second largest
		// term and the one below it, largest plus third largest, all-ones and bit patterns.
		corner_words = '{
			word_t'(0), word_t'(1), word_t'(2), word_t'(3), word_t'(4),
			word_t'(7), word_t'(12), word_t'(13),
			word_t'(fib_terms[NUM_FIBS-1]),
			word_t'(fib_terms[NUM_FIBS-1] - 1),
			word_t'(fib_terms[NUM_FIBS-1] + 1),
			word_t'(fib_terms[NUM_FIBS-2]),
			word_t'(fib_terms[NUM_FIBS-2] - 1),
			word_t'(fib_terms[NUM_FIBS-1] + fib_terms[NUM_FIBS-3]),
			{VALUE_WIDTH{1'b1}},
			word_t'(1) << (VALUE_WIDTH - 1),
			{(VALUE_WIDTH/2){2'b10}},
			{(VALUE_WIDTH/2){2'b01}}
		};
		foreach (corner_words[i]) begin
			operand_words = {operand_words, corner_words[i]};
			words_queued++;
		end

		// Three idling mixes; the bench holds off between them until every
		// owed code is back, so the encoder also restarts from empty.
		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < RANDOM_WORDS / 3 + (phase == 0 ? RANDOM_WORDS % 3 : 0); n++) begin
				operand_words = {operand_words, random_word()};
				words_queued++;
			end
			while (words_accepted != words_queued || zeck_codes_due.size() != 0)
				@(negedge clk);
			case (phase)
				0: begin
					sender_idle_pct   = 88;
					receiver_idle_pct = 21;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
		end

		// Let any stray result word show up before the verdict.
		repeat (70) @(negedge clk);

		$display("Encoded %0d words (%0d corner cases), %0d result words checked",
			words_accepted, corner_words.size(), codes_checked);
		$display("Largest term count %0d, top Fibonacci term used in %0d results",
			max_count_seen, top_term_hits);
		if (failures == 0 && zeck_codes_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d result words outstanding", zeck_codes_due.size());
		$display("TEST FAILED");
		$finish;
	end

endmodule
